// File: hw/rtl/spwm_pkg.sv
// ----------------------------------------------------------------------------
// spwm_pkg: shared types and constants of the servo PWM register writer
// Holds the action codes, register addresses, limits and the reciprocal
// constants used for division by fixed values.
// ----------------------------------------------------------------------------
package spwm_pkg;

  typedef enum logic [1:0] {
    ACT_RAW   = 2'd0,
    ACT_ALL   = 2'd1,
    ACT_PULSE = 2'd2,
    ACT_ANGLE = 2'd3
  } action_t;

  localparam logic [7:0]  REG_CH0     = 8'h06;
  localparam logic [7:0]  REG_ALL     = 8'hFA;
  localparam logic [3:0]  CH_MAX      = 4'd15;

  localparam logic [15:0] FREQ_RESET  = 16'd50;
  localparam logic [15:0] FREQ_MIN    = 16'd24;
  localparam logic [15:0] FREQ_MAX    = 16'd1526;
  localparam logic [24:0] OSC_HZ      = 25'd25000000;

  localparam logic [11:0] COUNT_MAX   = 12'd4095;
  localparam logic [15:0] SERVO_MIN   = 16'd400;
  localparam logic [15:0] SERVO_MAX   = 16'd3000;
  localparam logic [7:0]  ANGLE_MAX   = 8'd180;

  // floor(w / 45) = (w * DIV45_MULT) >> 24, exact for w < 2^17
  localparam logic [18:0] DIV45_MULT  = 19'd372828;
  // floor(y / 15625) = (y * DIV15625_MULT) >> 40, exact for y < 2^26
  localparam logic [26:0] DIV15625_MULT = 27'd70368745;
  // (x * 4096 + 500000) / 64 = x * 64 + 7812 after flooring
  localparam logic [33:0] ROUND_BIAS  = 34'd7812;
  // count exceeds 4095 when the scaled value reaches 4096 * 15625
  localparam logic [33:0] SAT_LIMIT   = 34'd64000000;

endpackage

// File: hw/rtl/servo_pwm_register_writer_core.sv
// ----------------------------------------------------------------------------
// servo_pwm_register_writer_core: PWM command to register write translator
// Turns raw counts, pulse widths and servo angles into a channel register
// write for a 16-channel 12-bit PWM controller, plus the prescale value.
// ----------------------------------------------------------------------------
// Throughput: one transaction per cycle when not stalled or busy with the
//   prescale divider, through a five-register pipeline (clamp and angle
//   multiply, divide by 180, pulse times frequency, divide by 10^6, output
//   register); a stall holds every full stage in place.
// Reset (rst, synchronous): frequency returns to 50 Hz, pipeline empties,
//   and the 8-step prescale divider runs; in_ready stays low while it runs,
//   and again while it reruns after each frequency write.
module servo_pwm_register_writer_core
  import spwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration
  input  logic               cfg_write_en,
  input  logic        [15:0] pwm_freq_hz,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic        [1:0]  action,
  input  logic        [7:0]  channel,
  input  logic        [15:0] on_ticks,
  input  logic        [15:0] off_ticks,
  input  logic        [15:0] pulse_width,
  input  logic signed [15:0] servo_angle,
  input  logic        [15:0] min_pulse_us,
  input  logic        [15:0] max_pulse_us,
  // output channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               write_valid,
  output logic        [7:0]  start_register,
  output logic        [7:0]  on_low_byte,
  output logic        [3:0]  on_high_nibble,
  output logic        [7:0]  off_low_byte,
  output logic        [3:0]  off_high_nibble,
  output logic        [7:0]  prescale_value
);

  // --------------------------------------------------------------------------
  // Prescale divider: q = floor(((25e6 + 2048 f) >> 12) / f), one bit a cycle
  // --------------------------------------------------------------------------
  logic [15:0] freq_src;
  logic [15:0] freq_lim;
  logic [24:0] numer_full;
  logic [10:0] freq_c;
  logic [12:0] div_rem;
  logic [7:0]  div_quot;
  logic [3:0]  div_cnt;
  logic [2:0]  div_idx;
  logic [17:0] div_trial;
  logic        div_take;

  always_comb begin
    freq_src = rst ? FREQ_RESET : pwm_freq_hz;
    if (freq_src < FREQ_MIN) begin
      freq_lim = FREQ_MIN;
    end else if (freq_src > FREQ_MAX) begin
      freq_lim = FREQ_MAX;
    end else begin
      freq_lim = freq_src;
    end
    numer_full = OSC_HZ + {3'b0, freq_lim[10:0], 11'b0};
    div_idx    = 3'(div_cnt - 4'd1);
    div_trial  = {7'b0, freq_c} << div_idx;
    div_take   = {5'b0, div_rem} >= div_trial;
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_write_en) begin
      freq_c   <= freq_lim[10:0];
      div_rem  <= numer_full[24:12];
      div_quot <= '0;
      div_cnt  <= 4'd8;
    end else if (div_cnt != 4'd0) begin
      if (div_take) begin
        div_rem           <= div_rem - div_trial[12:0];
        div_quot[div_idx] <= 1'b1;
      end
      div_cnt <= div_cnt - 4'd1;
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline handshake: each stage moves when the one after it has room
  // --------------------------------------------------------------------------
  logic s1_valid, s2_valid, s3_valid, s4_valid;
  logic s1_en, s2_en, s3_en, s4_en, o_en;

  assign o_en     = !out_valid || out_ready;
  assign s4_en    = !s4_valid || o_en;
  assign s3_en    = !s3_valid || s4_en;
  assign s2_en    = !s2_valid || s3_en;
  assign s1_en    = !s1_valid || s2_en;
  assign in_ready = s1_en && (div_cnt == 4'd0);

  // --------------------------------------------------------------------------
  // Stage 1: decode, clamp the servo limits, angle times span
  // --------------------------------------------------------------------------
  action_t     act;
  logic        ch_ok;
  logic [7:0]  a_c;
  logic [15:0] mn_c;
  logic [15:0] mx_c;
  logic [11:0] span;
  logic [7:0]  reg_addr;

  always_comb begin
    act   = action_t'(action);
    ch_ok = (act == ACT_ALL) || (channel <= {4'b0, CH_MAX});
    if (servo_angle < 0) begin
      a_c = 8'd0;
    end else if (servo_angle > $signed({8'b0, ANGLE_MAX})) begin
      a_c = ANGLE_MAX;
    end else begin
      a_c = servo_angle[7:0];
    end
    mn_c = (min_pulse_us < SERVO_MIN) ? SERVO_MIN : min_pulse_us;
    mx_c = (max_pulse_us > SERVO_MAX) ? SERVO_MAX : max_pulse_us;
    // span is at most 2600 when the maximum is above the minimum
    span = (mx_c > mn_c) ? 12'(mx_c - mn_c) : 12'd1;
    case (act)
      ACT_ALL: reg_addr = REG_ALL;
      default: reg_addr = REG_CH0 + {2'b0, channel[3:0], 2'b0};
    endcase
  end

  logic        s1_wv;
  logic [7:0]  s1_start;
  logic [11:0] s1_on;
  logic [11:0] s1_off;
  logic        s1_counts;
  logic        s1_servo;
  logic [15:0] s1_pulse;
  logic [15:0] s1_mn;
  logic [19:0] s1_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= in_valid && in_ready;
    end
    if (s1_en) begin
      s1_wv     <= ch_ok;
      s1_start  <= ch_ok ? reg_addr : 8'd0;
      s1_on     <= (ch_ok && (act == ACT_RAW || act == ACT_ALL)) ? on_ticks[11:0] : 12'd0;
      s1_off    <= (ch_ok && (act == ACT_RAW || act == ACT_ALL)) ? off_ticks[11:0] : 12'd0;
      s1_counts <= ch_ok && (act == ACT_PULSE || act == ACT_ANGLE);
      s1_servo  <= (act == ACT_ANGLE);
      s1_pulse  <= pulse_width;
      s1_mn     <= mn_c;
      s1_prod   <= {12'b0, a_c} * {8'b0, span};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by 180 as a quarter then a reciprocal multiply by 1/45
  // --------------------------------------------------------------------------
  logic        s2_wv;
  logic [7:0]  s2_start;
  logic [11:0] s2_on;
  logic [11:0] s2_off;
  logic        s2_counts;
  logic        s2_servo;
  logic [15:0] s2_pulse;
  logic [15:0] s2_mn;
  logic [35:0] s2_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_en) begin
      s2_valid <= s1_valid;
    end
    if (s2_en) begin
      s2_wv     <= s1_wv;
      s2_start  <= s1_start;
      s2_on     <= s1_on;
      s2_off    <= s1_off;
      s2_counts <= s1_counts;
      s2_servo  <= s1_servo;
      s2_pulse  <= s1_pulse;
      s2_mn     <= s1_mn;
      s2_prod   <= {19'b0, s1_prod[18:2]} * {17'b0, DIV45_MULT};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: pick the pulse width, multiply by the clamped frequency
  // --------------------------------------------------------------------------
  logic [16:0] pulse_sel;

  always_comb begin
    if (s2_servo) begin
      pulse_sel = {1'b0, s2_mn} + {5'b0, s2_prod[35:24]};
    end else begin
      pulse_sel = {1'b0, s2_pulse};
    end
  end

  logic        s3_wv;
  logic [7:0]  s3_start;
  logic [11:0] s3_on;
  logic [11:0] s3_off;
  logic        s3_counts;
  logic [27:0] s3_pf;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_en) begin
      s3_valid <= s2_valid;
    end
    if (s3_en) begin
      s3_wv     <= s2_wv;
      s3_start  <= s2_start;
      s3_on     <= s2_on;
      s3_off    <= s2_off;
      s3_counts <= s2_counts;
      s3_pf     <= {11'b0, pulse_sel} * {17'b0, freq_c};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: round, test for saturation, reciprocal multiply by 1/15625
  // --------------------------------------------------------------------------
  logic [33:0] scaled;

  assign scaled = {s3_pf, 6'b0} + ROUND_BIAS;

  logic        s4_wv;
  logic [7:0]  s4_start;
  logic [11:0] s4_on;
  logic [11:0] s4_off;
  logic        s4_counts;
  logic        s4_sat;
  logic [52:0] s4_prod;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_valid <= 1'b0;
    end else if (s4_en) begin
      s4_valid <= s3_valid;
    end
    if (s4_en) begin
      s4_wv     <= s3_wv;
      s4_start  <= s3_start;
      s4_on     <= s3_on;
      s4_off    <= s3_off;
      s4_counts <= s3_counts;
      s4_sat    <= scaled >= SAT_LIMIT;
      s4_prod   <= {27'b0, scaled[25:0]} * {26'b0, DIV15625_MULT};
    end
  end

  // --------------------------------------------------------------------------
  // Output register: choose the off count, split into bytes and nibbles
  // --------------------------------------------------------------------------
  logic [11:0] off_sel;

  always_comb begin
    if (!s4_counts) begin
      off_sel = s4_off;
    end else if (s4_sat) begin
      off_sel = COUNT_MAX;
    end else begin
      off_sel = s4_prod[51:40];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_en) begin
      out_valid <= s4_valid;
    end
    if (o_en) begin
      write_valid     <= s4_wv;
      start_register  <= s4_start;
      on_low_byte     <= s4_on[7:0];
      on_high_nibble  <= s4_on[11:8];
      off_low_byte    <= off_sel[7:0];
      off_high_nibble <= off_sel[11:8];
    end
  end

  // user must change frequency only while idle (unenforced), so the live divider is safe
  assign prescale_value = div_quot - 8'd1;

endmodule

// File: test/pwm_write_checker.sv
// ----------------------------------------------------------------------------
// pwm_write_checker: predicts and checks PWM register writes
// Watches the command, result and frequency ports of the register writer,
// works out the write that each accepted command must produce and compares
// every result transaction, field by field, with the oldest prediction.
// ----------------------------------------------------------------------------
module pwm_write_checker
  import spwm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write_en,
  input  logic        [15:0] pwm_freq_hz,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic        [1:0]  action,
  input  logic        [7:0]  channel,
  input  logic        [15:0] on_ticks,
  input  logic        [15:0] off_ticks,
  input  logic        [15:0] pulse_width,
  input  logic signed [15:0] servo_angle,
  input  logic        [15:0] min_pulse_us,
  input  logic        [15:0] max_pulse_us,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               write_valid,
  input  logic        [7:0]  start_register,
  input  logic        [7:0]  on_low_byte,
  input  logic        [3:0]  on_high_nibble,
  input  logic        [7:0]  off_low_byte,
  input  logic        [3:0]  off_high_nibble,
  input  logic        [7:0]  prescale_value,
  output int                 pending,
  output int                 fails
);

  localparam logic [63:0] COUNT_STEPS = 64'd4096;
  localparam logic [63:0] ROUND_HALF  = 64'd500000;
  localparam logic [63:0] US_PER_SEC  = 64'd1000000;

  typedef struct packed {
    logic       write_valid;
    logic [7:0] start_register;
    logic [7:0] on_low_byte;
    logic [3:0] on_high_nibble;
    logic [7:0] off_low_byte;
    logic [3:0] off_high_nibble;
    logic [7:0] prescale_value;
  } pwm_write_t;

  pwm_write_t  expected_writes[$];
  logic [15:0] freq_setting;
  int          fail_total = 0;
  int          outstanding = 0;

  assign fails   = fail_total;
  assign pending = outstanding;

  function automatic pwm_write_t translate_command(
    input action_t            act,
    input logic        [7:0]  ch,
    input logic        [15:0] on_raw,
    input logic        [15:0] off_raw,
    input logic        [15:0] pulse,
    input logic signed [15:0] angle,
    input logic        [15:0] min_raw,
    input logic        [15:0] max_raw,
    input logic        [15:0] freq_raw
  );
    pwm_write_t  w;
    logic [63:0] f, den, q, p, c, a, mn, mx;
    logic [11:0] on12, off12;
    begin
      f = 64'(freq_raw);
      if (f < 64'(FREQ_MIN)) f = 64'(FREQ_MIN);
      if (f > 64'(FREQ_MAX)) f = 64'(FREQ_MAX);
      // rounded oscillator divider, bounded to 1..256
      den = COUNT_STEPS * f;
      q   = (64'(OSC_HZ) + den / 64'd2) / den;
      if (q == 64'd0) q = 64'd1;
      if (q > 64'd256) q = 64'd256;
      w = '0;
      w.prescale_value = 8'(q - 64'd1);
      // a bad channel still reports the prescale value
      if (act != ACT_ALL && ch > {4'b0, CH_MAX}) return w;
      on12  = on_raw[11:0];
      off12 = off_raw[11:0];
      if (act == ACT_ALL) w.start_register = REG_ALL;
      else w.start_register = REG_CH0 + {ch[5:0], 2'b00};
      if (act == ACT_PULSE || act == ACT_ANGLE) begin
        p = 64'(pulse);
        if (act == ACT_ANGLE) begin
          if (angle < 16'sd0) a = 64'd0;
          else if (angle > $signed({8'd0, ANGLE_MAX})) a = 64'(ANGLE_MAX);
          else a = 64'(angle[15:0]);
          mn = 64'(min_raw);
          mx = 64'(max_raw);
          if (mn < 64'(SERVO_MIN)) mn = 64'(SERVO_MIN);
          if (mx > 64'(SERVO_MAX)) mx = 64'(SERVO_MAX);
          if (mx <= mn) mx = mn + 64'd1;
          p = mn + (a * (mx - mn)) / 64'(ANGLE_MAX);
        end
        c = (p * f * COUNT_STEPS + ROUND_HALF) / US_PER_SEC;
        if (c > 64'(COUNT_MAX)) c = 64'(COUNT_MAX);
        on12  = '0;
        off12 = c[11:0];
      end
      w.write_valid     = 1'b1;
      w.on_low_byte     = on12[7:0];
      w.on_high_nibble  = on12[11:8];
      w.off_low_byte    = off12[7:0];
      w.off_high_nibble = off12[11:8];
      return w;
    end
  endfunction

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    pwm_write_t w;
    if (rst) begin
      expected_writes.delete();
      freq_setting = FREQ_RESET;
    end else begin
      if (cfg_write_en) freq_setting = pwm_freq_hz;
      if (out_valid && out_ready) begin
        if (expected_writes.size() == 0) begin
          $error("result transaction with no command outstanding");
          fail_total++;
        end else begin
          w = expected_writes.pop_front();
          check_field("write_valid", w.write_valid, write_valid);
          check_field("start_register", w.start_register, start_register);
          check_field("on_low_byte", w.on_low_byte, on_low_byte);
          check_field("on_high_nibble", w.on_high_nibble, on_high_nibble);
          check_field("off_low_byte", w.off_low_byte, off_low_byte);
          check_field("off_high_nibble", w.off_high_nibble, off_high_nibble);
          check_field("prescale_value", w.prescale_value, prescale_value);
        end
      end
      if (in_valid && in_ready)
        expected_writes.push_back(translate_command(action_t'(action), channel, on_ticks,
          off_ticks, pulse_width, servo_angle, min_pulse_us, max_pulse_us, freq_setting));
    end
    outstanding <= expected_writes.size();
  end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench: servo PWM register writer, command stimulus and verdict
// Drives directed and random commands through the writer at a range of
// frequency settings, with random idling on both channels, and leaves the
// prediction and comparison of every register write to the checker.
// ----------------------------------------------------------------------------
module testbench;
  import spwm_pkg::*;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write_en = 1'b0;
  logic        [15:0] pwm_freq_hz = FREQ_RESET;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic        [1:0]  action = ACT_RAW;
  logic        [7:0]  channel = '0;
  logic        [15:0] on_ticks = '0;
  logic        [15:0] off_ticks = '0;
  logic        [15:0] pulse_width = '0;
  logic signed [15:0] servo_angle = '0;
  logic        [15:0] min_pulse_us = '0;
  logic        [15:0] max_pulse_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               write_valid;
  logic        [7:0]  start_register;
  logic        [7:0]  on_low_byte;
  logic        [3:0]  on_high_nibble;
  logic        [7:0]  off_low_byte;
  logic        [3:0]  off_high_nibble;
  logic        [7:0]  prescale_value;

  int   pending;
  int   fails;
  // set during the stretch in which neither side idles
  logic no_idle = 1'b0;

  always #1 clk = ~clk;

  servo_pwm_register_writer_core uut (
    .clk, .rst, .cfg_write_en, .pwm_freq_hz,
    .in_valid, .in_ready, .action, .channel, .on_ticks, .off_ticks,
    .pulse_width, .servo_angle, .min_pulse_us, .max_pulse_us,
    .out_valid, .out_ready, .write_valid, .start_register,
    .on_low_byte, .on_high_nibble, .off_low_byte, .off_high_nibble,
    .prescale_value
  );

  pwm_write_checker write_check (
    .clk, .rst, .cfg_write_en, .pwm_freq_hz,
    .in_valid, .in_ready, .action, .channel, .on_ticks, .off_ticks,
    .pulse_width, .servo_angle, .min_pulse_us, .max_pulse_us,
    .out_valid, .out_ready, .write_valid, .start_register,
    .on_low_byte, .on_high_nibble, .off_low_byte, .off_high_nibble,
    .prescale_value, .pending, .fails
  );

  // Stall the result channel at random about 11 percent of the time, except
  // during the quiet stretch.
  always @(posedge clk) begin
    out_ready <= no_idle || ($urandom_range(0, 99) >= 11);
  end

  // Abort the run if the block locks up.
  initial begin
    #400000;
    $display("Some tests failed");
    $finish;
  end

  // Present one command and hold it until the transaction completes. Idle
  // cycles go in front of it, so a gap may land behind any earlier command.
  // Return in the step of the accepting edge; the caller then either
  // presents the next command or drops valid, never both.
  task automatic send_command(
    input action_t            act,
    input logic        [7:0]  ch,
    input logic        [15:0] on_c,
    input logic        [15:0] off_c,
    input logic        [15:0] pulse,
    input logic signed [15:0] angle,
    input logic        [15:0] min_p,
    input logic        [15:0] max_p
  );
    while (!no_idle && $urandom_range(0, 99) < 11) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    action       <= act;
    channel      <= ch;
    on_ticks     <= on_c;
    off_ticks    <= off_c;
    pulse_width  <= pulse;
    servo_angle  <= angle;
    min_pulse_us <= min_p;
    max_pulse_us <= max_p;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly plausible servo and PWM commands, with a share of fully random
  // field values so that every bit toggles.
  task automatic send_random_command();
    action_t     act;
    logic [7:0]  ch;
    logic [15:0] pulse, min_p, max_p;
    logic [15:0] angle;
    act   = action_t'($urandom_range(0, 3));
    ch    = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    pulse = ($urandom_range(0, 99) < 70) ? 16'($urandom_range(0, 5000)) : 16'($urandom);
    if ($urandom_range(0, 99) < 70) angle = 16'($signed($urandom_range(0, 230)) - 25);
    else angle = 16'($urandom);
    if ($urandom_range(0, 99) < 70) begin
      min_p = 16'($urandom_range(200, 1500));
      max_p = 16'($urandom_range(1000, 3500));
    end else begin
      min_p = 16'($urandom);
      max_p = 16'($urandom);
    end
    send_command(act, ch, 16'($urandom), 16'($urandom), pulse, angle, min_p, max_p);
  endtask

  // Drop valid and hold off until the checker has seen every result.
  task automatic drain_writes();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write the frequency register with the block idle.
  task automatic set_frequency(input logic [15:0] freq);
    drain_writes();
    cfg_write_en <= 1'b1;
    pwm_freq_hz  <= freq;
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  initial begin
    logic [15:0] freq_plan[8];
    freq_plan = '{16'd0, FREQ_MIN, FREQ_MAX, 16'hFFFF, 16'd23, 16'd1527,
                  16'($urandom_range(24, 1526)), FREQ_RESET};

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed commands at the reset frequency. Raw counts: extremes and
    // the bits above the 12-bit mask, plus rejected channels.
    send_command(ACT_RAW,   8'd0,   16'h0000, 16'h0000, 16'd0, 16'sd0, 16'd0, 16'd0);
    send_command(ACT_RAW,   8'd15,  16'hFFFF, 16'hFFFF, 16'd0, 16'sd0, 16'd0, 16'd0);
    send_command(ACT_RAW,   8'd16,  16'h0123, 16'h0456, 16'd0, 16'sd0, 16'd0, 16'd0);
    send_command(ACT_RAW,   8'd255, 16'hFFFF, 16'hFFFF, 16'd0, 16'sd0, 16'd0, 16'd0);
    // all-channel block ignores the channel field
    send_command(ACT_ALL,   8'd200, 16'h1234, 16'hABCD, 16'd0, 16'sd0, 16'd0, 16'd0);
    send_command(ACT_ALL,   8'd0,   16'h0000, 16'hFFFF, 16'd0, 16'sd0, 16'd0, 16'd0);
    // pulse widths: zero, typical, saturating, bad channel
    send_command(ACT_PULSE, 8'd3,   16'hFFFF, 16'hFFFF, 16'd0,     16'sd0, 16'd0, 16'd0);
    send_command(ACT_PULSE, 8'd7,   16'd0,    16'd0,    16'd1500,  16'sd0, 16'd0, 16'd0);
    send_command(ACT_PULSE, 8'd15,  16'd0,    16'd0,    16'hFFFF,  16'sd0, 16'd0, 16'd0);
    send_command(ACT_PULSE, 8'd16,  16'd0,    16'd0,    16'd1000,  16'sd0, 16'd0, 16'd0);
    // angles: clamping at both ends and through the range
    send_command(ACT_ANGLE, 8'd1,   16'd0, 16'd0, 16'd0, -16'sd32768, 16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd1,   16'd0, 16'd0, 16'd0, -16'sd1,     16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd2,   16'd0, 16'd0, 16'd0, 16'sd0,      16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd2,   16'd0, 16'd0, 16'd0, 16'sd90,     16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd4,   16'd0, 16'd0, 16'd0, 16'sd180,    16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd4,   16'd0, 16'd0, 16'd0, 16'sd181,    16'd500, 16'd2500);
    send_command(ACT_ANGLE, 8'd5,   16'd0, 16'd0, 16'd0, 16'sd32767,  16'd500, 16'd2500);
    // pulse limits: minimum raised, maximum capped, maximum forced above
    // the minimum, and a minimum so large that its successor needs 17 bits
    send_command(ACT_ANGLE, 8'd6,   16'd0, 16'd0, 16'd0, 16'sd180, 16'd0,    16'hFFFF);
    send_command(ACT_ANGLE, 8'd6,   16'd0, 16'd0, 16'd0, 16'sd180, 16'd2000, 16'd1000);
    send_command(ACT_ANGLE, 8'd8,   16'd0, 16'd0, 16'd0, 16'sd180, 16'hFFFF, 16'd0);
    send_command(ACT_ANGLE, 8'd8,   16'd0, 16'd0, 16'd0, 16'sd45,  16'd400,  16'd3000);
    send_command(ACT_ANGLE, 8'd200, 16'd0, 16'd0, 16'd0, 16'sd90,  16'd400,  16'd3000);

    // Random phases, one per frequency setting, the clamping edges among
    // them. The third phase runs with no idling on either side, and the
    // fourth pauses halfway until every result is back.
    foreach (freq_plan[i]) begin
      set_frequency(freq_plan[i]);
      no_idle <= (i == 2);
      for (int n = 0; n < 150; n++) begin
        if (i == 3 && n == 75) drain_writes();
        send_random_command();
      end
    end

    // Wait for the last results and give the pipeline time to settle.
    drain_writes();
    repeat (20) @(posedge clk);
    if (fails == 0 && pending == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
